// File: src/c_subset_lexer_defines.svh
// ----------------------------------------------------------------------------
// c_subset_lexer_defines: assertion macros used by the lexer rtl
// clock clk_i and reset rst_ni are taken from the module that uses them
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: src/clx_pkg.sv
// ----------------------------------------------------------------------------
// clx_pkg
// types, tables and character classes of the c subset lexer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package clx_pkg;

  localparam int unsigned PosW    = 17;  // holds the text limit itself
  localparam int unsigned OffW    = 16;
  localparam logic [7:0]  EscCode = 8'h1B;
  localparam logic [31:0] NumSat  = 32'h7FFF_FFFF;
  localparam logic [15:0] LenSat  = 16'hFFFF;

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_NUM, M_OP, M_CH_OPEN, M_CH_ESC, M_CH_CLOSE,
    M_STR, M_STR_BS, M_DRAIN
  } clx_mode_e;

  typedef enum logic [2:0] {
    TK_NUMBER, TK_STRING, TK_NAME, TK_KEYWORD, TK_PUNCT, TK_OPER, TK_END, TK_ERROR
  } clx_kind_e;

  typedef enum logic [2:0] {
    ER_NONE, ER_CHAR_CUT, ER_CHAR_OPEN, ER_STR_OPEN, ER_BAD_CHAR
  } clx_err_e;

  localparam logic [3:0] KwAlignof = 4'd13;

  typedef struct packed {
    clx_kind_e   kind;
    logic [7:0]  sym;
    logic [3:0]  word;
    logic [31:0] val;
    logic [15:0] start;
    logic [15:0] len;
    clx_err_e    err;
  } clx_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    clx_res_t   r0;
    clx_res_t   r1;
  } clx_bundle_t;

  function automatic clx_res_t mk_res(clx_kind_e k, logic [7:0] s, logic [3:0] w,
                                      logic [31:0] v, logic [15:0] st,
                                      logic [15:0] l, clx_err_e e);
    clx_res_t r;
    r.kind = k; r.sym = s; r.word = w; r.val = v; r.start = st; r.len = l; r.err = e;
    return r;
  endfunction

  function automatic logic [15:0] grow(logic [15:0] l, logic [1:0] by);
    logic [16:0] s;
    s = {1'b0, l} + {15'd0, by};
    return s[16] ? LenSat : s[15:0];
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_punct(logic [7:0] b);
    logic r;
    case (b)
      "+", "-", "*", "/", "=", ";", "(", ")", ",", "{", "}", ">", "<", "&",
      "[", "]", "|", "!", "^", "?", ":", "~", "%", ".": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic starts_op(logic [7:0] b);
    logic r;
    case (b)
      "=", "!", "&", "|", "<", ">", "+", "-": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // {hit, index}
  function automatic logic [4:0] op_lookup(logic [7:0] h, logic [7:0] b);
    logic [4:0] r;
    case ({h, b})
      16'("=="): r = {1'b1, 4'd0};
      16'("!="): r = {1'b1, 4'd1};
      16'("&&"): r = {1'b1, 4'd2};
      16'("||"): r = {1'b1, 4'd3};
      16'("<="): r = {1'b1, 4'd4};
      16'(">="): r = {1'b1, 4'd5};
      16'("<<"): r = {1'b1, 4'd6};
      16'(">>"): r = {1'b1, 4'd7};
      16'("++"): r = {1'b1, 4'd8};
      16'("--"): r = {1'b1, 4'd9};
      16'("->"): r = {1'b1, 4'd10};
      default:   r = 5'd0;
    endcase
    return r;
  endfunction

  // word buffer holds the first byte highest, zero above the word
  function automatic logic [4:0] kw_lookup(logic [63:0] w);
    logic [4:0] r;
    case (w)
      64'("if"):       r = {1'b1, 4'd0};
      64'("else"):     r = {1'b1, 4'd1};
      64'("return"):   r = {1'b1, 4'd2};
      64'("while"):    r = {1'b1, 4'd3};
      64'("for"):      r = {1'b1, 4'd4};
      64'("void"):     r = {1'b1, 4'd5};
      64'("int"):      r = {1'b1, 4'd6};
      64'("char"):     r = {1'b1, 4'd7};
      64'("struct"):   r = {1'b1, 4'd8};
      64'("typedef"):  r = {1'b1, 4'd9};
      64'("sizeof"):   r = {1'b1, 4'd10};
      64'("extern"):   r = {1'b1, 4'd11};
      64'("do"):       r = {1'b1, 4'd12};
      64'("_Alignof"): r = {1'b1, KwAlignof};
      64'("break"):    r = {1'b1, 4'd14};
      default:         r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] escape_of(logic [7:0] b);
    logic [7:0] r;
    case (b)
      "a":      r = 8'd7;
      "b":      r = 8'd8;
      "t":      r = 8'd9;
      "n":      r = 8'd10;
      "v":      r = 8'd11;
      "f":      r = 8'd12;
      "r":      r = 8'd13;
      "e", "E": r = EscCode;
      default:  r = b;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/clx_scan.sv
// ----------------------------------------------------------------------------
// clx_scan
// scanner state and per-byte token logic, one word per cycle while accept_i is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module clx_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  input  logic                end_i,
  output clx_pkg::clx_bundle_t bundle_o
);
  import clx_pkg::*;

  clx_mode_e    mode_q, mode_d;
  logic [7:0]   held_q, held_d;
  logic [63:0]  wb_q, wb_d;
  logic [31:0]  acc_q, acc_d;
  logic [15:0]  tstart_q, tstart_d;
  logic [15:0]  len_q, len_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic         long_q, long_d;

  logic         a_v, b_v, do_start, is_end;
  clx_res_t     a_r, b_r;
  logic [4:0]   kw, op;
  logic [15:0]  len1;
  logic [35:0]  prod;
  logic [31:0]  sext;

  always_comb begin
    mode_d = mode_q; held_d = held_q; wb_d = wb_q; acc_d = acc_q;
    tstart_d = tstart_q; len_d = len_q; pos_d = pos_q; long_d = long_q;
    a_v = 1'b0; b_v = 1'b0; do_start = 1'b0;
    a_r = '0; b_r = '0;
    len1 = grow(len_q, 2'd1);
    kw = kw_lookup(wb_q);
    op = op_lookup(held_q, byte_i);
    prod = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + {28'd0, byte_i - 8'd48};
    sext = {{24{held_q[7]}}, held_q};
    is_end = end_i || byte_i == 8'd0 || pos_q[PosW-1];

    if (is_end) begin
      a_v = 1'b1;
      case (mode_q)
        M_WORD: begin
          if (kw[4] && !long_q && len_q <= 16'd8)
            a_r = mk_res(TK_KEYWORD, 8'd0, kw[3:0], '0, tstart_q, len_q, ER_NONE);
          else
            a_r = mk_res(TK_NAME, 8'd0, 4'd0, '0, tstart_q, len_q, ER_NONE);
        end
        M_NUM:  a_r = mk_res(TK_NUMBER, 8'd0, 4'd0, acc_q, tstart_q, len_q, ER_NONE);
        M_OP:   a_r = mk_res(TK_PUNCT, held_q, 4'd0, '0, tstart_q, 16'd1, ER_NONE);
        M_CH_OPEN, M_CH_ESC:
          a_r = mk_res(TK_ERROR, 8'd0, 4'd0, '0, tstart_q, 16'd0, ER_CHAR_CUT);
        M_CH_CLOSE:
          a_r = mk_res(TK_ERROR, 8'd0, 4'd0, '0, tstart_q, 16'd0, ER_CHAR_OPEN);
        M_STR, M_STR_BS:
          a_r = mk_res(TK_ERROR, 8'd0, 4'd0, '0, tstart_q, 16'd0, ER_STR_OPEN);
        default: a_v = 1'b0;
      endcase
      b_v = 1'b1;
      b_r = mk_res(TK_END, 8'd0, 4'd0, '0, pos_q[OffW-1:0], 16'd0, ER_NONE);
      mode_d = M_IDLE;
      pos_d = '0;
    end else begin
      pos_d = pos_q + 1'b1;
      case (mode_q)
        M_WORD: begin
          if (is_alpha(byte_i) || is_digit(byte_i) || byte_i == "_") begin
            if (len_q < 16'd8) wb_d = {wb_q[55:0], byte_i};
            else long_d = 1'b1;
            len_d = len1;
            // _Alignof ends at its eighth byte whatever follows
            if (len1 == 16'd8 && wb_d == 64'("_Alignof")) begin
              a_v = 1'b1;
              a_r = mk_res(TK_KEYWORD, 8'd0, KwAlignof, '0, tstart_q, 16'd8, ER_NONE);
              mode_d = M_IDLE;
            end
          end else begin
            a_v = 1'b1;
            if (kw[4] && !long_q && len_q <= 16'd8)
              a_r = mk_res(TK_KEYWORD, 8'd0, kw[3:0], '0, tstart_q, len_q, ER_NONE);
            else
              a_r = mk_res(TK_NAME, 8'd0, 4'd0, '0, tstart_q, len_q, ER_NONE);
            do_start = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(byte_i)) begin
            acc_d = (prod > {4'd0, NumSat}) ? NumSat : prod[31:0];
            len_d = len1;
          end else begin
            a_v = 1'b1;
            a_r = mk_res(TK_NUMBER, 8'd0, 4'd0, acc_q, tstart_q, len_q, ER_NONE);
            do_start = 1'b1;
          end
        end
        M_OP: begin
          a_v = 1'b1;
          if (op[4]) begin
            a_r = mk_res(TK_OPER, {4'd0, op[3:0]}, 4'd0, '0, tstart_q, 16'd2, ER_NONE);
            mode_d = M_IDLE;
          end else begin
            a_r = mk_res(TK_PUNCT, held_q, 4'd0, '0, tstart_q, 16'd1, ER_NONE);
            do_start = 1'b1;
          end
        end
        M_CH_OPEN: begin
          len_d = len1;
          if (byte_i == "\\") mode_d = M_CH_ESC;
          else begin
            held_d = byte_i;
            mode_d = M_CH_CLOSE;
          end
        end
        M_CH_ESC: begin
          len_d = len1;
          held_d = escape_of(byte_i);
          mode_d = M_CH_CLOSE;
        end
        M_CH_CLOSE: begin
          a_v = 1'b1;
          if (byte_i == "'") begin
            a_r = mk_res(TK_NUMBER, 8'd0, 4'd0, sext, tstart_q, len1, ER_NONE);
            mode_d = M_IDLE;
          end else begin
            a_r = mk_res(TK_ERROR, 8'd0, 4'd0, '0, tstart_q, 16'd0, ER_CHAR_OPEN);
            mode_d = M_DRAIN;
          end
        end
        M_STR, M_STR_BS: begin
          if (mode_q == M_STR_BS && byte_i == "\"") begin
            // escaped quote stays inside the string
            len_d = grow(len_q, 2'd2);
            mode_d = M_STR;
          end else begin
            if (mode_q == M_STR_BS) len_d = len1;
            if (byte_i == "\"") begin
              a_v = 1'b1;
              a_r = mk_res(TK_STRING, 8'd0, 4'd0, '0, tstart_q, len_d, ER_NONE);
              mode_d = M_IDLE;
            end else if (byte_i == "\\") begin
              mode_d = M_STR_BS;
            end else begin
              len_d = grow(len_d, 2'd1);
              mode_d = M_STR;
            end
          end
        end
        M_DRAIN: ;
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        mode_d = M_IDLE;
        if (!is_space(byte_i)) begin
          tstart_d = pos_q[OffW-1:0];
          if (byte_i == "'") begin
            mode_d = M_CH_OPEN;
            len_d = 16'd1;
          end else if (byte_i == "\"") begin
            mode_d = M_STR;
            len_d = 16'd0;
          end else if (starts_op(byte_i)) begin
            mode_d = M_OP;
            held_d = byte_i;
          end else if (is_punct(byte_i)) begin
            b_v = 1'b1;
            b_r = mk_res(TK_PUNCT, byte_i, 4'd0, '0, pos_q[OffW-1:0], 16'd1, ER_NONE);
          end else if (is_alpha(byte_i) || byte_i == "_") begin
            mode_d = M_WORD;
            wb_d = {56'd0, byte_i};
            len_d = 16'd1;
            long_d = 1'b0;
          end else if (is_digit(byte_i)) begin
            mode_d = M_NUM;
            acc_d = {24'd0, byte_i - 8'd48};
            len_d = 16'd1;
          end else begin
            b_v = 1'b1;
            b_r = mk_res(TK_ERROR, 8'd0, 4'd0, '0, pos_q[OffW-1:0], 16'd0, ER_BAD_CHAR);
            mode_d = M_DRAIN;
          end
        end
      end
    end

    bundle_o.cnt = {1'b0, a_v} + {1'b0, b_v};
    bundle_o.r0  = a_v ? a_r : b_r;
    bundle_o.r1  = b_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; held_q <= '0; wb_q <= '0; acc_q <= '0;
      tstart_q <= '0; len_q <= '0; pos_q <= '0; long_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d; held_q <= held_d; wb_q <= wb_d; acc_q <= acc_d;
      tstart_q <= tstart_d; len_q <= len_d; pos_q <= pos_d; long_q <= long_d;
    end
  end

endmodule
`default_nettype wire

// File: src/clx_emit.sv
// ----------------------------------------------------------------------------
// clx_emit
// result register of two slots, hands tokens out one word per cycle while take_i is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "c_subset_lexer_defines.svh"
module clx_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  clx_pkg::clx_bundle_t bundle_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 take_i,
  output clx_pkg::clx_res_t    res_o,
  output logic                 last_o
);
  import clx_pkg::*;

  logic [1:0] n_q, n_d;
  clx_res_t   s0_q, s0_d, s1_q, s1_d;
  logic       pop;

  assign valid_o = n_q != 2'd0;
  assign pop     = valid_o && take_i;
  assign ready_o = (n_q == 2'd0) || (n_q == 2'd1 && take_i);
  assign res_o   = s0_q;
  assign last_o  = n_q == 2'd1;

  always_comb begin
    n_d = n_q; s0_d = s0_q; s1_d = s1_q;
    if (pop) begin
      n_d = n_q - 2'd1;
      s0_d = s1_q;
    end
    if (push_i) begin
      n_d = bundle_i.cnt;
      s0_d = bundle_i.r0;
      s1_d = bundle_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) n_q <= 2'd0;
    else n_q <= n_d;
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  `ASSERT_NEVER(a_push_ready, push_i && !ready_o, "push while result register full")
  `ASSERT_AT(a_push_shows, push_i && bundle_i.cnt != 2'd0 |=> valid_o, "pushed token lost")
  `ASSERT_NEVER(a_cnt_range, n_q == 2'd3, "slot count out of range")
  `ASSERT_AT(a_hold, valid_o && !take_i |=> valid_o && $stable(n_q), "stalled count moved")

endmodule
`default_nettype wire

// File: src/c_subset_lexer.sv
// ----------------------------------------------------------------------------
// c_subset_lexer
// streaming lexer for a small c subset, one text byte in, tokens out
// ----------------------------------------------------------------------------
//  channel  dir  tdata                        tuser        tlast
//  s_axis   in   [7:0] text_byte              -            end_of_text
//  m_axis   out  see port comment             token_kind   last_of_run
//
//  one byte is taken per cycle while s_axis_tready is high; the scanner state
//  updates in that cycle and the tokens it completes (zero to two) land in a
//  two-slot result register; tokens leave one per cycle while m_axis_tready
//  is high, so a byte causing two tokens holds the input until its second token leaves
//  reset clears scanner state and the text position to zero
//  s_axis_tready drops while a token waits and m_axis_tready is low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module c_subset_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // symbol_code[7:0] word_index[11:8] number_value[43:12] start_offset[59:44]
  // token_length[75:60] error_code[78:76] zero[79]
  output logic [79:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // token_kind
  output logic        m_axis_tlast    // last_of_run
);
  import clx_pkg::*;

  logic        accept;
  clx_bundle_t bundle;
  clx_res_t    res;

  assign accept = s_axis_tvalid && s_axis_tready;

  clx_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .end_i    (s_axis_tlast),
    .bundle_o (bundle)
  );

  clx_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .bundle_i (bundle),
    .ready_o  (s_axis_tready),
    .valid_o  (m_axis_tvalid),
    .take_i   (m_axis_tready),
    .res_o    (res),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {1'b0, res.err, res.len, res.start, res.val, res.word, res.sym};

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for c_subset_lexer
// drives source text byte by byte on s_axis, predicts every token in a
// behavioral scanner and checks each m_axis word in order, with random gaps
// on both sides and a long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import clx_pkg::*;

  localparam int unsigned TextLimit  = 65536;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct {
    clx_kind_e   kind;
    logic [7:0]  sym;
    logic [3:0]  word;
    logic [31:0] val;
    logic [15:0] start;
    logic [15:0] len;
    clx_err_e    err;
    logic        last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // text_byte
  logic        s_axis_tlast = 1'b0;   // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // symbol_code, word_index, number_value, start_offset, token_length, error_code
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;          // token_kind
  logic        m_axis_tlast;

  c_subset_lexer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  token_t      expected_tokens[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          no_gaps = 1'b0;
  int unsigned hold_off = 0;

  // scanner copy
  clx_mode_e   mode = M_IDLE;
  logic [7:0]  held = 8'd0;
  logic [7:0]  wbuf[8];
  logic [31:0] acc = 32'd0;
  logic [16:0] tok_start = 17'd0;
  logic [15:0] lex_len = 16'd0;
  logic [16:0] text_pos = 17'd0;
  logic        too_long = 1'b0;

  string kw_names[15] = '{"if", "else", "return", "while", "for", "void", "int", "char",
                          "struct", "typedef", "sizeof", "extern", "do", "_Alignof",
                          "break"};
  string op_names[11] = '{"==", "!=", "&&", "||", "<=", ">=", "<<", ">>", "++", "--",
                          "->"};
  string punct_chars = "+-*/=;(),{}><&[]|!^?:~%.";

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] add_len(logic [15:0] l, int unsigned by);
    logic [16:0] s;
    s = {1'b0, l} + 17'(by);
    return s[16] ? LenSat : s[15:0];
  endfunction

  function automatic bit alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic bit digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic bit punct(logic [7:0] b);
    for (int i = 0; i < punct_chars.len(); i++) if (punct_chars[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit op_head(logic [7:0] b);
    for (int i = 0; i < 11; i++) if (op_names[i][0] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit buf_is(int idx);
    for (int j = 0; j < kw_names[idx].len(); j++) if (wbuf[j] != kw_names[idx][j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void push_token(clx_kind_e k, logic [7:0] s, logic [3:0] w,
                                     logic [31:0] v, logic [16:0] st, logic [15:0] l,
                                     clx_err_e e);
    token_t t;
    t.kind = k; t.sym = s; t.word = w; t.val = v; t.start = st[15:0]; t.len = l;
    t.err = e; t.last = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  function automatic void raise_error(clx_err_e e, logic [16:0] st);
    push_token(TK_ERROR, 8'd0, 4'd0, 32'd0, st, 16'd0, e);
    mode = M_DRAIN;
  endfunction

  function automatic void flush_word();
    if (!too_long && lex_len <= 16'd8) begin
      for (int i = 0; i < 15; i++) begin
        if (kw_names[i].len() == lex_len && buf_is(i)) begin
          push_token(TK_KEYWORD, 8'd0, 4'(i), 32'd0, tok_start, lex_len, ER_NONE);
          return;
        end
      end
    end
    push_token(TK_NAME, 8'd0, 4'd0, 32'd0, tok_start, lex_len, ER_NONE);
  endfunction

  function automatic void open_token(logic [7:0] b);
    mode = M_IDLE;
    if (b == 8'h20 || (b >= 8'd9 && b <= 8'd13)) return;
    tok_start = text_pos;
    if (b == "'") begin
      mode = M_CH_OPEN;
      lex_len = 16'd1;
    end else if (b == "\"") begin
      mode = M_STR;
      lex_len = 16'd0;
    end else if (op_head(b)) begin
      mode = M_OP;
      held = b;
    end else if (punct(b)) begin
      push_token(TK_PUNCT, b, 4'd0, 32'd0, text_pos, 16'd1, ER_NONE);
    end else if (alpha(b) || b == "_") begin
      mode = M_WORD;
      foreach (wbuf[i]) wbuf[i] = 8'd0;
      wbuf[0] = b;
      lex_len = 16'd1;
      too_long = 1'b0;
    end else if (digit(b)) begin
      mode = M_NUM;
      acc = 32'(b - 8'h30);
      lex_len = 16'd1;
    end else begin
      raise_error(ER_BAD_CHAR, text_pos);
    end
  endfunction

  function automatic void string_char(logic [7:0] b);
    if (b == "\"") begin
      push_token(TK_STRING, 8'd0, 4'd0, 32'd0, tok_start, lex_len, ER_NONE);
      mode = M_IDLE;
    end else if (b == "\\") begin
      mode = M_STR_BS;
    end else begin
      lex_len = add_len(lex_len, 1);
      mode = M_STR;
    end
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] b);
    case (b)
      "a": return 8'd7;
      "b": return 8'd8;
      "t": return 8'd9;
      "n": return 8'd10;
      "v": return 8'd11;
      "f": return 8'd12;
      "r": return 8'd13;
      "e", "E": return 8'h1B;
      default: return b;
    endcase
  endfunction

  function automatic void scan_char(logic [7:0] b);
    logic [63:0] v;
    case (mode)
      M_WORD: begin
        if (alpha(b) || digit(b) || b == "_") begin
          if (lex_len < 16'd8) wbuf[lex_len[2:0]] = b;
          else too_long = 1'b1;
          lex_len = add_len(lex_len, 1);
          // _Alignof closes as soon as its eighth byte is in
          if (lex_len == 16'd8 && buf_is(13)) begin
            push_token(TK_KEYWORD, 8'd0, KwAlignof, 32'd0, tok_start, 16'd8, ER_NONE);
            mode = M_IDLE;
          end
        end else begin
          flush_word();
          open_token(b);
        end
      end
      M_NUM: begin
        if (digit(b)) begin
          v = 64'(acc) * 64'd10 + 64'(b - 8'h30);
          acc = (v > 64'(NumSat)) ? NumSat : v[31:0];
          lex_len = add_len(lex_len, 1);
        end else begin
          push_token(TK_NUMBER, 8'd0, 4'd0, acc, tok_start, lex_len, ER_NONE);
          open_token(b);
        end
      end
      M_OP: begin
        for (int i = 0; i < 11; i++) begin
          if (op_names[i][0] == held && op_names[i][1] == b) begin
            push_token(TK_OPER, 8'(i), 4'd0, 32'd0, tok_start, 16'd2, ER_NONE);
            mode = M_IDLE;
            return;
          end
        end
        push_token(TK_PUNCT, held, 4'd0, 32'd0, tok_start, 16'd1, ER_NONE);
        open_token(b);
      end
      M_CH_OPEN: begin
        lex_len = add_len(lex_len, 1);
        if (b == "\\") mode = M_CH_ESC;
        else begin
          held = b;
          mode = M_CH_CLOSE;
        end
      end
      M_CH_ESC: begin
        lex_len = add_len(lex_len, 1);
        held = unescape(b);
        mode = M_CH_CLOSE;
      end
      M_CH_CLOSE: begin
        if (b == "'") begin
          push_token(TK_NUMBER, 8'd0, 4'd0, {{24{held[7]}}, held}, tok_start,
                     add_len(lex_len, 1), ER_NONE);
          mode = M_IDLE;
        end else raise_error(ER_CHAR_OPEN, tok_start);
      end
      M_STR: string_char(b);
      M_STR_BS: begin
        if (b == "\"") begin
          lex_len = add_len(lex_len, 2);
          mode = M_STR;
        end else begin
          lex_len = add_len(lex_len, 1);
          string_char(b);
        end
      end
      M_DRAIN: ;
      default: open_token(b);
    endcase
  endfunction

  function automatic void close_text();
    case (mode)
      M_WORD: flush_word();
      M_NUM: push_token(TK_NUMBER, 8'd0, 4'd0, acc, tok_start, lex_len, ER_NONE);
      M_OP: push_token(TK_PUNCT, held, 4'd0, 32'd0, tok_start, 16'd1, ER_NONE);
      M_CH_OPEN, M_CH_ESC: raise_error(ER_CHAR_CUT, tok_start);
      M_CH_CLOSE: raise_error(ER_CHAR_OPEN, tok_start);
      M_STR, M_STR_BS: raise_error(ER_STR_OPEN, tok_start);
      default: ;
    endcase
    push_token(TK_END, 8'd0, 4'd0, 32'd0, text_pos, 16'd0, ER_NONE);
    mode = M_IDLE;
    text_pos = 17'd0;
  endfunction

  function automatic void lex_word(logic [7:0] b, logic eot);
    int n;
    n = expected_tokens.size();
    if (eot || b == 8'd0 || text_pos >= 17'(TextLimit)) close_text();
    else begin
      scan_char(b);
      text_pos = text_pos + 17'd1;
    end
    if (expected_tokens.size() > n) expected_tokens[$].last = 1'b1;
  endfunction

  task automatic send_word(logic [7:0] b, logic eot);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    lex_word(b, eot);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    send_word(8'($urandom), 1'b1);
  endtask

  // receiver: per-word stall, plus a long hold-off on request
  int unsigned stall = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      m_axis_tready <= (stall == 0);
    end else if (stall > 0) begin
      stall = stall - 1;
      m_axis_tready <= (stall == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    token_t e;
    logic [79:0] d;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      d = m_axis_tdata;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token kind %0d data %h", m_axis_tuser, d);
      end else begin
        e = expected_tokens.pop_front();
        if (m_axis_tuser != e.kind || d[7:0] != e.sym || d[11:8] != e.word ||
            d[43:12] != e.val || d[59:44] != e.start || d[75:60] != e.len ||
            d[78:76] != e.err || d[79] != 1'b0 || m_axis_tlast != e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("token mismatch: exp kind %0d sym %0d kw %0d val %0d at %0d len %0d",
                     e.kind, e.sym, e.word, e.val, e.start, e.len,
                     " err %0d last %0b", e.err, e.last);
            $display("                act kind %0d sym %0d kw %0d val %0d at %0d len %0d",
                     m_axis_tuser, d[7:0], d[11:8], d[43:12], d[59:44], d[75:60],
                     " err %0d last %0b", d[78:76], m_axis_tlast);
          end
        end
      end
    end
  end

  task automatic test_keywords_and_operators();
    string s;
    s = "";
    foreach (kw_names[i]) s = {s, kw_names[i], " "};
    send_text({s, "_Alignofx"});
    s = "";
    foreach (op_names[i]) s = {s, op_names[i], " "};
    send_text({s, punct_chars});
  endtask

  task automatic test_literals();
    send_text("0 2147483647 2147483648 99999999999 12ab");
    send_text("'a' '\\n' '\\e' '\\E' '\\0' '\\a''\\b''\\t''\\v''\\f''\\r'");
    send_text({"'", string'(8'hFF), "'", " \"ab\\\"c\\d\" \"\""});
    send_word("x", 1'b0);
    send_word(8'd0, 1'b0);   // zero byte ends the text
  endtask

  task automatic test_errors();
    send_text({"a ", string'(8'h80), " b"});
    send_text("\\");
    send_text("@");
    send_text("'");
    send_text("'\\");
    send_text("'a");
    send_text("'ab' x");
    send_text("\"open");
    send_text("\"open\\");
  endtask

  function automatic string random_lexeme();
    string s;
    int unsigned n;
    case ($urandom_range(0, 9))
      0: return kw_names[$urandom_range(0, 14)];
      1: return op_names[$urandom_range(0, 10)];
      2: begin
        s = "";
        s = {s, string'(punct_chars[$urandom_range(0, punct_chars.len() - 1)])};
        return s;
      end
      3: return $sformatf("%0d", $urandom_range(0, 99999));
      4: begin
        s = string'(8'($urandom_range(32, 126)));
        return {"'", s, "'"};
      end
      5: begin
        if ($urandom_range(0, 1)) s = "a\\\"b";
        else s = "xy z";
        return {"\"", s, "\""};
      end
      6: begin
        n = $urandom_range(1, 11);
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'(($urandom_range(0, 3) == 0) ?
                                                   "_" : $urandom_range(97, 122)))};
        return s;
      end
      7: return "9";
      default: return " ";
    endcase
  endfunction

  task automatic test_random_text();
    int unsigned sent;
    string s;
    sent = 0;
    while (sent < 40) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      s = "";
      for (int i = 0; i < $urandom_range(2, 8); i++) begin
        s = {s, random_lexeme()};
        if ($urandom_range(0, 1)) s = {s, " "};
      end
      // some texts carry a raw byte anywhere in the range
      if ($urandom_range(0, 4) == 0) s = {s, string'(8'($urandom_range(1, 255)))};
      send_text(s);
      sent += s.len() + 1;
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_output_hold_off();
    no_gaps = 1'b1;
    hold_off = 80;
    send_text("a+b,c;1 2 3 (x) [y] {z} ! ~ ? : %");
    no_gaps = 1'b0;
  endtask

  initial begin
    foreach (wbuf[i]) wbuf[i] = 8'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_keywords_and_operators();
    test_literals();
    test_errors();
    test_output_hold_off();
    test_random_text();
    s_axis_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
